// ===== design/pwl_pkg.sv =====
// ----------------------------------------------------------------------------
// pwl_pkg - shared types and constants of the piecewise-linear lookup unit
// Sequencer states, operation codes and the packing of the stream words.
// ----------------------------------------------------------------------------
package pwl_pkg;

    // operation codes carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // field widths
    localparam int IDX_FIELD_W = 4;
    localparam int VAL_W       = 16;
    localparam int CNT_W       = 5;

    // input word layout, lowest bit first
    localparam int S_IDX_LSB  = 0;
    localparam int S_KEY_LSB  = S_IDX_LSB + IDX_FIELD_W;
    localparam int S_VOLT_LSB = S_KEY_LSB + VAL_W;
    localparam int S_QRY_LSB  = S_VOLT_LSB + VAL_W;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 16;

    // divider length: magnitude of the product fits 32 bits
    localparam int DIV_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TAIL,
        ST_SCAN,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } pwl_state_t;

endpackage

// ===== design/piecewise_linear_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_lookup_unit - velocity to voltage interpolation table
// A write word, or a query on an empty table, goes straight to DONE; other
// queries clamp or run the serial segment scan (one table read a cycle) and
// a 32-step shift-subtract divider. One word is worked on at a time; a result
// may wait in the output register while the next word is taken. Synchronous
// active-low reset clears control state and entry_count; table data undefined.
// ----------------------------------------------------------------------------
module piecewise_linear_lookup_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: entry_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pwl_pkg::CNT_W-1:0]      cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, from bit 0: entry_index[3:0], entry_velocity[19:4],
    // entry_voltage[35:20], query_velocity[51:36], zero pad [55:52]
    input  logic [pwl_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: operation (0 write entry, 1 query)
    input  logic                           s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: voltage_out[15:0]
    output logic [pwl_pkg::M_DATA_W-1:0]   m_tdata,
    // m_tuser: is_query_result
    output logic                           m_tuser
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int N_W    = $clog2(MAX_ENTRIES + 1);
    localparam int VW     = pwl_pkg::VAL_W;
    localparam int DW     = pwl_pkg::DIV_W;
    localparam int STEP_W = $clog2(DW);

    // ------------------------------------------------------------------
    // Unpack the input word
    // ------------------------------------------------------------------
    logic [pwl_pkg::IDX_FIELD_W-1:0] s_idx;
    logic signed [VW-1:0]            s_key;
    logic signed [VW-1:0]            s_volt;
    logic signed [VW-1:0]            s_qry;

    assign s_idx  = s_tdata[pwl_pkg::S_IDX_LSB +: pwl_pkg::IDX_FIELD_W];
    assign s_key  = s_tdata[pwl_pkg::S_KEY_LSB +: VW];
    assign s_volt = s_tdata[pwl_pkg::S_VOLT_LSB +: VW];
    assign s_qry  = s_tdata[pwl_pkg::S_QRY_LSB +: VW];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    pwl_pkg::pwl_state_t state_reg, state_next;

    logic [pwl_pkg::CNT_W-1:0] count_reg;

    // table memories, one write and one registered read port each
    logic [VW-1:0] key_mem [MAX_ENTRIES];
    logic [VW-1:0] val_mem [MAX_ENTRIES];
    logic signed [VW-1:0] rd_key_reg;
    logic signed [VW-1:0] rd_val_reg;

    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] k1_reg, v1_reg;   // lower end of the segment
    logic signed [VW-1:0] k2_reg, v2_reg;   // upper end of the segment
    logic [IDX_W-1:0]     j_reg;            // index of entry now on the read port

    logic signed [2*VW+1:0] prod_reg;
    logic [VW-1:0]          den_reg;
    logic                   neg_reg;
    logic [DW-1:0]          quo_reg;
    logic [VW-1:0]          rem_reg;
    logic [STEP_W-1:0]      step_reg;

    logic [VW-1:0] res_reg;
    logic          res_query_reg;

    logic                 m_tvalid_reg;
    logic [VW-1:0]        m_tdata_reg;
    logic                 m_tuser_reg;

    // ------------------------------------------------------------------
    // Entries in use: saturate the count at the table depth
    // ------------------------------------------------------------------
    logic [N_W-1:0] n_use;
    logic [N_W-1:0] n_last;

    assign n_use  = (32'(count_reg) > 32'(MAX_ENTRIES)) ? N_W'(MAX_ENTRIES)
                                                        : N_W'(count_reg);
    assign n_last = n_use - N_W'(1);

    // ------------------------------------------------------------------
    // Compares and arithmetic shared by the sequencer steps
    // ------------------------------------------------------------------
    logic x_le_rd, x_ge_rd, x_ge_k1, seg_hit, scan_end, out_free;

    assign x_le_rd  = (x_reg <= rd_key_reg);
    assign x_ge_rd  = (x_reg >= rd_key_reg);
    assign x_ge_k1  = (x_reg >= k1_reg);
    assign seg_hit  = x_ge_k1 && x_le_rd;
    assign scan_end = (N_W'(j_reg) == n_last);
    assign out_free = !m_tvalid_reg || m_tready;

    logic signed [VW:0] dx, dv;
    assign dx = {x_reg[VW-1], x_reg} - {k1_reg[VW-1], k1_reg};
    assign dv = {v2_reg[VW-1], v2_reg} - {v1_reg[VW-1], v1_reg};

    logic [VW:0]   den_ext;
    assign den_ext = {k2_reg[VW-1], k2_reg} - {k1_reg[VW-1], k1_reg};

    logic [2*VW+1:0] prod_mag;
    assign prod_mag = prod_reg[2*VW+1] ? -prod_reg : prod_reg;

    // one shift-subtract step of the divider
    logic [VW:0] trial;
    logic        trial_ge;
    logic [VW:0] trial_diff;
    assign trial      = {rem_reg, quo_reg[DW-1]};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};

    // quotient never exceeds the span of the two values: 17 bits do
    logic signed [VW+1:0] q_signed;
    logic signed [VW+1:0] fin_sum;
    assign q_signed = neg_reg ? -$signed({1'b0, quo_reg[VW:0]})
                              :  $signed({1'b0, quo_reg[VW:0]});
    assign fin_sum  = {{2{v1_reg[VW-1]}}, v1_reg} + q_signed;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pwl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == pwl_pkg::OP_WRITE || n_use == '0) begin
                        state_next = pwl_pkg::ST_DONE;
                    end else begin
                        state_next = pwl_pkg::ST_HEAD;
                    end
                end
            end
            pwl_pkg::ST_HEAD: begin
                // one entry, or at or below the first key: clamp low
                if (n_use == N_W'(1) || x_le_rd) begin
                    state_next = pwl_pkg::ST_DONE;
                end else begin
                    state_next = pwl_pkg::ST_TAIL;
                end
            end
            pwl_pkg::ST_TAIL: begin
                // at or above the last key: clamp high
                if (x_ge_rd) begin
                    state_next = pwl_pkg::ST_DONE;
                end else begin
                    state_next = pwl_pkg::ST_SCAN;
                end
            end
            pwl_pkg::ST_SCAN: begin
                if (seg_hit) begin
                    state_next = pwl_pkg::ST_MUL;
                end else if (scan_end) begin
                    state_next = pwl_pkg::ST_DONE;
                end
            end
            pwl_pkg::ST_MUL: begin
                if (k2_reg == k1_reg) begin
                    state_next = pwl_pkg::ST_DONE;
                end else begin
                    state_next = pwl_pkg::ST_PREP;
                end
            end
            pwl_pkg::ST_PREP: begin
                state_next = pwl_pkg::ST_DIV;
            end
            pwl_pkg::ST_DIV: begin
                if (step_reg == STEP_W'(DW - 1)) begin
                    state_next = pwl_pkg::ST_FIN;
                end
            end
            pwl_pkg::ST_FIN: begin
                state_next = pwl_pkg::ST_DONE;
            end
            pwl_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pwl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pwl_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: handshake and table read address
    // ------------------------------------------------------------------
    logic             in_ready;
    logic [IDX_W-1:0] rd_idx;

    always_comb begin
        in_ready = 1'b0;
        rd_idx   = '0;
        case (state_reg)
            pwl_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                rd_idx   = '0;
            end
            pwl_pkg::ST_HEAD: begin
                rd_idx = IDX_W'(n_last);
            end
            pwl_pkg::ST_TAIL: begin
                rd_idx = IDX_W'(1);
            end
            pwl_pkg::ST_SCAN: begin
                // reads past the last entry, wrapping at full depth; that read is never used
                rd_idx = j_reg + IDX_W'(1);
            end
            default: begin
                rd_idx = '0;
            end
        endcase
    end

    assign s_tready  = in_ready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pwl_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                count_reg <= cfg_data;
            end
            // output register: load when the finished result moves out of DONE
            if (state_reg == pwl_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Table memories: write on an accepted write word, read every cycle
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid && s_tuser == pwl_pkg::OP_WRITE &&
            32'(s_idx) < 32'(MAX_ENTRIES)) begin
            key_mem[IDX_W'(s_idx)] <= s_key;
            val_mem[IDX_W'(s_idx)] <= s_volt;
        end
        rd_key_reg <= key_mem[rd_idx];
        rd_val_reg <= val_mem[rd_idx];
    end

    // ------------------------------------------------------------------
    // Datapath registers, stepped by the sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            pwl_pkg::ST_IDLE: begin
                x_reg         <= s_qry;
                res_reg       <= '0;
                res_query_reg <= (s_tuser == pwl_pkg::OP_QUERY);
            end
            pwl_pkg::ST_HEAD: begin
                // hold entry 0 as the lower end of the first segment
                res_reg <= rd_val_reg;
                k1_reg  <= rd_key_reg;
                v1_reg  <= rd_val_reg;
                j_reg   <= IDX_W'(1);
            end
            pwl_pkg::ST_TAIL: begin
                res_reg <= rd_val_reg;
            end
            pwl_pkg::ST_SCAN: begin
                if (seg_hit) begin
                    k2_reg <= rd_key_reg;
                    v2_reg <= rd_val_reg;
                end else begin
                    // advance: upper end becomes the next lower end
                    k1_reg <= rd_key_reg;
                    v1_reg <= rd_val_reg;
                    j_reg  <= j_reg + IDX_W'(1);
                end
                // no segment matched: answer zero
                res_reg <= '0;
            end
            pwl_pkg::ST_MUL: begin
                // equal keys give the lower value
                res_reg  <= v1_reg;
                prod_reg <= dx * dv;
                den_reg  <= den_ext[VW-1:0];
            end
            pwl_pkg::ST_PREP: begin
                neg_reg  <= prod_reg[2*VW+1];
                quo_reg  <= prod_mag[DW-1:0];
                rem_reg  <= '0;
                step_reg <= '0;
            end
            pwl_pkg::ST_DIV: begin
                rem_reg  <= trial_ge ? trial_diff[VW-1:0] : trial[VW-1:0];
                quo_reg  <= {quo_reg[DW-2:0], trial_ge};
                step_reg <= step_reg + STEP_W'(1);
            end
            pwl_pkg::ST_FIN: begin
                res_reg <= fin_sum[VW-1:0];
            end
            pwl_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= res_reg;
                    m_tuser_reg <= res_query_reg;
                end
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== tb/pwl_lookup_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_lookup_checker - answer checker for the piecewise-linear lookup unit
// Watches the configuration, input and result channels, keeps a private copy
// of the table and entry count, predicts every answer and compares it in order.
// ----------------------------------------------------------------------------
module pwl_lookup_checker #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [pwl_pkg::CNT_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // s_tdata, from bit 0: entry_index, entry_velocity, entry_voltage,
    // query_velocity, zero pad
    input  logic [pwl_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: operation
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: voltage_out
    input  logic [pwl_pkg::M_DATA_W-1:0]   m_tdata,
    // m_tuser: is_query_result
    input  logic                           m_tuser,
    output int                             error_count,
    output int                             outstanding
);

    localparam int VW = pwl_pkg::VAL_W;
    localparam int IW = pwl_pkg::IDX_FIELD_W;

    typedef struct packed {
        logic [VW-1:0] voltage;
        logic          is_query;
    } lookup_answer_t;

    lookup_answer_t       answers_due[$];
    logic signed [VW-1:0] key_tab  [MAX_ENTRIES];
    logic signed [VW-1:0] volt_tab [MAX_ENTRIES];
    int                   active_entries = 0;
    int                   fault_tally    = 0;
    int                   due_count      = 0;
    int                   answer_seq     = 0;

    assign error_count = fault_tally;
    assign outstanding = due_count;

    task automatic report_mismatch(input string what);
        $display("%0t voltage check: %s", $time, what);
        fault_tally++;
    endtask

    // clamp outside the key range, otherwise interpolate on the first segment
    // that holds x; the quotient truncates toward zero
    function automatic logic signed [VW-1:0] interpolate_voltage(
        input logic signed [VW-1:0] x);
        int     n;
        longint k_lo, k_hi, v_lo, v_hi, quotient;
        n = active_entries;
        if (n == 0) return '0;
        if (n == 1) return volt_tab[0];
        if (x <= key_tab[0]) return volt_tab[0];
        if (x >= key_tab[n-1]) return volt_tab[n-1];
        for (int i = 0; i + 1 < n; i++) begin
            k_lo = key_tab[i];
            k_hi = key_tab[i+1];
            v_lo = volt_tab[i];
            v_hi = volt_tab[i+1];
            if (longint'(x) >= k_lo && longint'(x) <= k_hi) begin
                if (k_hi == k_lo) return VW'(v_lo);
                quotient = ((longint'(x) - k_lo) * (v_hi - v_lo)) / (k_hi - k_lo);
                return VW'(v_lo + quotient);
            end
        end
        return '0;
    endfunction

    always @(posedge aclk) begin
        lookup_answer_t want;
        logic [IW-1:0]  slot;
        if (!aresetn) begin
            answers_due.delete();
            active_entries = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                active_entries = (cfg_data > MAX_ENTRIES) ? MAX_ENTRIES
                                                          : int'(cfg_data);

            if (s_tvalid && s_tready) begin
                if (s_tuser == pwl_pkg::OP_WRITE) begin
                    slot = s_tdata[pwl_pkg::S_IDX_LSB +: IW];
                    if (slot < MAX_ENTRIES) begin
                        key_tab[slot]  = s_tdata[pwl_pkg::S_KEY_LSB  +: VW];
                        volt_tab[slot] = s_tdata[pwl_pkg::S_VOLT_LSB +: VW];
                    end
                    want.voltage  = '0;
                    want.is_query = 1'b0;
                end else begin
                    want.voltage  = interpolate_voltage(s_tdata[pwl_pkg::S_QRY_LSB +: VW]);
                    want.is_query = 1'b1;
                end
                answers_due.push_back(want);
            end

            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("word %0d arrived with nothing due", answer_seq));
                end else begin
                    want = answers_due.pop_front();
                    if (m_tuser !== want.is_query)
                        report_mismatch($sformatf("word %0d is_query_result %b, want %b",
                                                  answer_seq, m_tuser, want.is_query));
                    if (m_tdata !== want.voltage)
                        report_mismatch($sformatf("word %0d voltage_out %0d, want %0d",
                                                  answer_seq, $signed(m_tdata),
                                                  $signed(want.voltage)));
                end
                answer_seq++;
            end
        end
        due_count <= answers_due.size();
    end

endmodule

// ===== tb/tb_piecewise_linear_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_lookup_unit - stimulus and verdict for the lookup unit
// Fills the table with sorted and scrambled entries under many entry counts,
// fires queries on keys, between keys and past both ends, and stalls both
// channels at random; pwl_lookup_checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_lookup_unit;

    localparam int TABLE_DEPTH = 16;
    localparam int WORD_TARGET = 600;      // start no new phase after this many words
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int CYCLE_LIMIT = 500000;   // several times the slowest clean run
    localparam int SETTLE      = 80;       // longest query plus margin
    localparam int VW          = pwl_pkg::VAL_W;
    localparam int IW          = pwl_pkg::IDX_FIELD_W;
    localparam int CW          = pwl_pkg::CNT_W;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CW-1:0]                 cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    // s_tdata, from bit 0: entry_index, entry_velocity, entry_voltage,
    // query_velocity, zero pad
    logic [pwl_pkg::S_DATA_W-1:0]  s_tdata;
    // s_tuser: operation
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    // m_tdata: voltage_out
    logic [pwl_pkg::M_DATA_W-1:0]  m_tdata;
    // m_tuser: is_query_result
    logic                          m_tuser;

    int   mismatches;
    int   outstanding;
    int   items_sent = 0;
    logic long_hold  = 1'b0;
    bit   s_quiet    = 1'b0;
    bit   m_quiet    = 1'b0;

    always #6 aclk = ~aclk;

    piecewise_linear_lookup_unit #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    pwl_lookup_checker #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) answer_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (mismatches),
        .outstanding (outstanding)
    );

    // mostly random 16-bit values, with the two extremes showing up often
    function automatic logic [VW-1:0] pick16();
        logic [VW-1:0] r;
        case ($urandom_range(0, 7))
            0: r = 16'h8000;
            1: r = 16'h7fff;
            default: r = VW'($urandom);
        endcase
        return r;
    endfunction

    // Offer one word. Draw the idle gap first; keep tvalid high across
    // back-to-back words so it is never lowered and raised in the same step.
    task automatic offer_word(input logic op, input logic [IW-1:0] idx,
                              input logic [VW-1:0] key, input logic [VW-1:0] volt,
                              input logic [VW-1:0] qry);
        int gap;
        logic [pwl_pkg::S_DATA_W-1:0] word;
        word = '0;
        word[pwl_pkg::S_IDX_LSB  +: IW] = idx;
        word[pwl_pkg::S_KEY_LSB  +: VW] = key;
        word[pwl_pkg::S_VOLT_LSB +: VW] = volt;
        word[pwl_pkg::S_QRY_LSB  +: VW] = qry;
        // swap between idling and flat-out stretches now and then
        if ($urandom_range(0, 24) == 0) s_quiet = !s_quiet;
        gap = s_quiet ? 0 : int'($urandom_range(0, 16));
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // unused fields carry random bits; the block must ignore them
    task automatic put_entry(input logic [IW-1:0] idx,
                             input logic [VW-1:0] key, input logic [VW-1:0] volt);
        offer_word(pwl_pkg::OP_WRITE, idx, key, volt, VW'($urandom));
    endtask

    task automatic ask(input logic [VW-1:0] velocity);
        offer_word(pwl_pkg::OP_QUERY, IW'($urandom), VW'($urandom), VW'($urandom),
                   velocity);
    endtask

    // drop tvalid and hold until every expected word has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // change entry_count only with the block idle
    task automatic set_entry_count(input logic [CW-1:0] count);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result side: draw a wait per word, honour the long hold-off, then
    // accept. Never lower and raise tready in the same step.
    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 24) == 0) m_quiet = !m_quiet;
            gap = m_quiet ? 0 : int'($urandom_range(0, 16));
            if (gap != 0 || long_hold) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                while (long_hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Back-pressure: once the random part is under way, hold the result side
    // off for a long stretch so the block fills and stalls its input.
    initial begin
        wait (items_sent >= 150);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_piecewise_linear_lookup_unit: errors");
        $finish;
    end

    initial begin
        int phase;
        int used;
        int step_max;
        int k;
        int j;
        int x;
        logic [CW-1:0]        count;
        logic signed [VW-1:0] keys [TABLE_DEPTH];

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= pwl_pkg::OP_WRITE;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // empty table answers zero at both velocity extremes
        ask(16'h8000);
        ask(16'h7fff);
        // a single entry answers its value everywhere
        set_entry_count(5'd1);
        put_entry(4'd0, 16'h8000, 16'h8000);
        ask(16'h7fff);
        ask(16'h0000);
        // full-span segment: clamps at the ends, widest product inside
        set_entry_count(5'd2);
        put_entry(4'd1, 16'h7fff, 16'h7fff);
        ask(16'h8000);
        ask(16'h7fff);
        ask(16'h0000);
        ask(16'h0001);
        ask(16'hffff);
        // top slot, outside the active range
        put_entry(4'd15, pick16(), pick16());
        // repeated last key
        set_entry_count(5'd3);
        put_entry(4'd2, 16'h7fff, 16'hfffb);
        ask(16'h7fff);
        ask(16'd16000);
        // unsorted table: last key below the first segment's end
        set_entry_count(5'd4);
        put_entry(4'd3, -16'sd1000, 16'sd1234);
        ask(-16'sd500);
        ask(-16'sd20000);

        // ---- random part ----
        // Each phase picks an entry count (extremes first, including counts
        // above the table depth), fills the active slots with ascending keys
        // and then mixes targeted queries with stray writes.
        phase = 0;
        while (items_sent < WORD_TARGET) begin
            case (phase)
                0: count = 5'd0;
                1: count = 5'd1;
                2: count = 5'd2;
                3: count = 5'd16;
                4: count = 5'd17;
                5: count = 5'd31;
                default: count = CW'($urandom_range(0, 31));
            endcase
            set_entry_count(count);
            used = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);

            // step size sets how dense the keys are; zero steps give repeats
            case ($urandom_range(0, 2))
                0: step_max = 3;
                1: step_max = 300;
                default: step_max = 4369;
            endcase
            k = int'($urandom_range(0, 65535 - 15 * step_max)) - 32768;
            for (int s = 0; s < used; s++) begin
                keys[s] = VW'(k);
                put_entry(IW'(s), VW'(k), pick16());
                k += int'($urandom_range(0, step_max));
            end

            repeat ($urandom_range(20, 40)) begin
                case ($urandom_range(0, 9))
                    0: put_entry(IW'($urandom_range(0, 15)), pick16(), pick16());
                    1, 2: ask(pick16());
                    3, 4: begin
                        if (used > 0) ask(keys[$urandom_range(0, used - 1)]);
                        else ask(pick16());
                    end
                    default: begin
                        if (used > 0) begin
                            j = int'($urandom_range(0, used - 1));
                            x = int'(keys[j]);
                            x += int'($urandom_range(0, step_max + 1));
                            if (x > 32767) x = 32767;
                            ask(VW'(x));
                        end else begin
                            ask(pick16());
                        end
                    end
                endcase
            end
            phase++;
        end

        // let every answer drain, then allow the block to settle
        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_piecewise_linear_lookup_unit: clean");
        else
            $display("tb_piecewise_linear_lookup_unit: errors");
        $finish;
    end

endmodule
